>>> src/blci_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the line rasterizer with color interpolation.
// No dependencies; every other file refers to this package by scoped names.
package blci_pkg;

  localparam int FRAME_WIDTH     = 512;
  localparam int COLOR_FRAC_BITS = 16;
  localparam int BYTES_PER_PIXEL = 4;

  localparam int COORD_W   = 9;
  localparam int COLOR_W   = 8;
  localparam int ADDR_W    = 20;
  localparam int ERR_W     = 12;
  localparam int INC_S_W   = 11;
  localparam int STEPS_W   = 10;
  localparam int DVR_W     = COORD_W;
  localparam int ACC_W     = COLOR_W + COLOR_FRAC_BITS;
  localparam int STEP_W    = ACC_W + 1;
  localparam int DIV_CNT_W = $clog2(ACC_W + 1);
  localparam int NUM_CH    = 3;
  localparam int CH_W      = 2;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0] start_red;
    logic [COLOR_W-1:0] start_green;
    logic [COLOR_W-1:0] start_blue;
    logic [COLOR_W-1:0] start_alpha;
    logic [COLOR_W-1:0] end_red;
    logic [COLOR_W-1:0] end_green;
    logic [COLOR_W-1:0] end_blue;
  } in_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_red;
    logic [COLOR_W-1:0] pixel_green;
    logic [COLOR_W-1:0] pixel_blue;
    logic [COLOR_W-1:0] pixel_alpha;
    logic [ADDR_W-1:0]  byte_address;
    logic               last_pixel;
  } out_word_t;

  // Byte offset of the pixel's red byte, low ADDR_W bits kept.
  function automatic logic [ADDR_W-1:0] pixel_addr(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
    logic [31:0] a;
    a = 32'(x) * 32'(BYTES_PER_PIXEL) + 32'(y) * 32'(BYTES_PER_PIXEL * FRAME_WIDTH);
    return a[ADDR_W-1:0];
  endfunction

endpackage

>>> src/bresenham_line_color_interp_unit.sv
`timescale 1ns / 1ps
// Line rasterizer for all octants with per-channel color interpolation.
// Depends on blci_pkg and blci_divider.
//
//   channel  ports                         word type
//   input    in_valid, in_stall, in_word   blci_pkg::in_word_t
//   output   out_valid, out_stall, out_word blci_pkg::out_word_t
//
// A start word emits its first pixel into the output register on the next cycle, then
// runs three divisions on the shared divider, and in_stall stays high while they run.
// A line whose endpoints match skips the divisions. An advance word steps the line and
// emits its next pixel into the output register.
// in_stall also rises while a finished word waits in the output register under out_stall.
// rst_n is synchronous and clears the sequencer, the step count, the active flag and out_valid.
module bresenham_line_color_interp_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  blci_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output blci_pkg::out_word_t  out_word
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  localparam int COORD_W = blci_pkg::COORD_W;
  localparam int COLOR_W = blci_pkg::COLOR_W;
  localparam int ACC_W   = blci_pkg::ACC_W;
  localparam int STEP_W  = blci_pkg::STEP_W;
  localparam int ERR_W   = blci_pkg::ERR_W;
  localparam int CH_W    = blci_pkg::CH_W;
  localparam int NUM_CH  = blci_pkg::NUM_CH;

  // Sequencer and line state
  logic                         state_r;
  logic [CH_W-1:0]              ch_r;
  logic                         go_r;
  logic                         active_r;
  logic [blci_pkg::STEPS_W-1:0] steps_r;
  logic [COORD_W-1:0]           cur_x_r;
  logic [COORD_W-1:0]           cur_y_r;
  logic                         dxn_r;
  logic                         dyn_r;
  logic                         major_x_r;
  logic [ERR_W-1:0]             err_r;
  logic [blci_pkg::INC_S_W-1:0] inc_s_r;
  logic [ERR_W-1:0]             inc_d_r;
  logic [COLOR_W-1:0]           alpha_r;
  logic [blci_pkg::DVR_W-1:0]   major_r;
  logic [ACC_W-1:0]             acc_r   [NUM_CH];
  logic [STEP_W-1:0]            step_r  [NUM_CH];
  logic [COLOR_W-1:0]           dmag_r  [NUM_CH];
  logic                         dneg_r  [NUM_CH];
  logic                         out_valid_r;
  blci_pkg::out_word_t          out_word_r;

  logic                in_acc;
  logic                emit_start;
  logic                emit_adv;
  blci_pkg::out_word_t word_nxt;

  // Start setup
  logic [COORD_W-1:0] sx, sy, ex, ey, dx, dy, major, minor;
  logic               dxn, dyn, major_x;
  logic [COLOR_W-1:0] sc [NUM_CH];
  logic [COLOR_W-1:0] ec [NUM_CH];

  // Advance
  logic                         move_minor;
  logic [ERR_W-1:0]             err_nxt;
  logic [COORD_W-1:0]           x_nxt, y_nxt;
  logic [ACC_W-1:0]             acc_nxt [NUM_CH];
  logic [blci_pkg::STEPS_W-1:0] steps_nxt;

  // Divider
  logic             div_done;
  logic [ACC_W-1:0] div_q;
  logic [ACC_W-1:0] div_dividend;
  logic [STEP_W-1:0] step_nxt;

  assign in_stall   = (state_r == ST_DIV) || (out_valid_r && out_stall);
  assign in_acc     = in_valid && !in_stall;
  assign emit_start = in_acc && (in_word.opcode == blci_pkg::OP_START);
  assign emit_adv   = in_acc && (in_word.opcode == blci_pkg::OP_ADVANCE) && active_r;

  always_comb begin
    sx = in_word.start_x;
    sy = in_word.start_y;
    ex = in_word.end_x;
    ey = in_word.end_y;
    sc[0] = in_word.start_red;
    sc[1] = in_word.start_green;
    sc[2] = in_word.start_blue;
    ec[0] = in_word.end_red;
    ec[1] = in_word.end_green;
    ec[2] = in_word.end_blue;
    dxn = ex < sx;
    dyn = ey < sy;
    dx  = dxn ? sx - ex : ex - sx;
    dy  = dyn ? sy - ey : ey - sy;
    major_x = dy <= dx;
    major = major_x ? dx : dy;
    minor = major_x ? dy : dx;
  end

  always_comb begin
    move_minor = $signed(err_r) > $signed(ERR_W'(0));
    err_nxt    = err_r + (move_minor ? inc_d_r : ERR_W'(inc_s_r));
    x_nxt      = cur_x_r;
    y_nxt      = cur_y_r;
    if (major_x_r || move_minor) begin
      x_nxt = dxn_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
    end
    if (!major_x_r || move_minor) begin
      y_nxt = dyn_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
    end
    for (int k = 0; k < NUM_CH; k++) begin
      acc_nxt[k] = acc_r[k] + step_r[k][ACC_W-1:0];
    end
    steps_nxt = steps_r - 1'b1;
  end

  always_comb begin
    if (emit_start) begin
      word_nxt.pixel_x      = sx;
      word_nxt.pixel_y      = sy;
      word_nxt.pixel_red    = sc[0];
      word_nxt.pixel_green  = sc[1];
      word_nxt.pixel_blue   = sc[2];
      word_nxt.pixel_alpha  = in_word.start_alpha;
      word_nxt.byte_address = blci_pkg::pixel_addr(sx, sy);
      word_nxt.last_pixel   = major == '0;
    end else begin
      word_nxt.pixel_x      = x_nxt;
      word_nxt.pixel_y      = y_nxt;
      word_nxt.pixel_red    = acc_nxt[0][ACC_W-1 -: COLOR_W];
      word_nxt.pixel_green  = acc_nxt[1][ACC_W-1 -: COLOR_W];
      word_nxt.pixel_blue   = acc_nxt[2][ACC_W-1 -: COLOR_W];
      word_nxt.pixel_alpha  = alpha_r;
      word_nxt.byte_address = blci_pkg::pixel_addr(x_nxt, y_nxt);
      word_nxt.last_pixel   = steps_nxt == '0;
    end
  end

  assign div_dividend = {dmag_r[ch_r], {blci_pkg::COLOR_FRAC_BITS{1'b0}}};
  assign step_nxt     = dneg_r[ch_r] ? STEP_W'(0) - {1'b0, div_q} : {1'b0, div_q};

  blci_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (go_r),
    .dividend (div_dividend),
    .divisor  (major_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      go_r        <= 1'b0;
      active_r    <= 1'b0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      go_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (emit_start && major != '0) begin
            state_r <= ST_DIV;
            ch_r    <= '0;
            go_r    <= 1'b1;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (ch_r == CH_W'(NUM_CH - 1)) begin
              state_r <= ST_IDLE;
            end else begin
              ch_r <= ch_r + 1'b1;
              go_r <= 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      if (emit_start) begin
        steps_r  <= blci_pkg::STEPS_W'(major);
        active_r <= major != '0;
      end else if (emit_adv) begin
        steps_r  <= steps_nxt;
        active_r <= steps_nxt != '0;
      end

      if (emit_start || emit_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Line data path
  always_ff @(posedge clk) begin
    if (emit_start) begin
      cur_x_r   <= sx;
      cur_y_r   <= sy;
      dxn_r     <= dxn;
      dyn_r     <= dyn;
      major_x_r <= major_x;
      err_r     <= ERR_W'({minor, 1'b0}) - ERR_W'(major);
      inc_s_r   <= blci_pkg::INC_S_W'({minor, 1'b0});
      inc_d_r   <= ERR_W'({minor, 1'b0}) - ERR_W'({major, 1'b0});
      alpha_r   <= in_word.start_alpha;
      major_r   <= major;
      for (int k = 0; k < NUM_CH; k++) begin
        acc_r[k]  <= {sc[k], {blci_pkg::COLOR_FRAC_BITS{1'b0}}};
        step_r[k] <= '0;
        dneg_r[k] <= ec[k] < sc[k];
        dmag_r[k] <= (ec[k] < sc[k]) ? sc[k] - ec[k] : ec[k] - sc[k];
      end
    end else if (emit_adv) begin
      cur_x_r <= x_nxt;
      cur_y_r <= y_nxt;
      err_r   <= err_nxt;
      for (int k = 0; k < NUM_CH; k++) begin
        acc_r[k] <= acc_nxt[k];
      end
    end else if (state_r == ST_DIV && div_done) begin
      step_r[ch_r] <= step_nxt;
    end
  end

  // Hold the word while stalled
  always_ff @(posedge clk) begin
    if (emit_start || emit_adv) begin
      out_word_r <= word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the division phase");

  a_stall_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> in_stall)
    else $error("input open while color steps are computed");

  a_adv_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
    emit_adv |-> steps_r != '0)
    else $error("advance on a line with no steps left");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_start || emit_adv) && word_nxt.last_pixel |=> !active_r && out_valid_r)
    else $error("last pixel did not end the line");

endmodule

>>> src/blci_divider.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle, shared by the color channels.
// Depends on blci_pkg for widths.
module blci_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [blci_pkg::ACC_W-1:0] dividend,
  input  logic [blci_pkg::DVR_W-1:0] divisor,
  output logic                       done,
  output logic [blci_pkg::ACC_W-1:0] quotient
);

  logic                           busy_r;
  logic                           done_r;
  logic [blci_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [blci_pkg::ACC_W-1:0]     dvd_r;
  logic [blci_pkg::DVR_W-1:0]     rem_r;
  logic [blci_pkg::DVR_W-1:0]     dvr_r;

  logic [blci_pkg::DVR_W:0] rem_sh;
  logic [blci_pkg::DVR_W:0] rem_sub;
  logic                     fits;

  assign rem_sh  = {rem_r, dvd_r[blci_pkg::ACC_W-1]};
  assign fits    = rem_sh >= {1'b0, dvr_r};
  assign rem_sub = rem_sh - {1'b0, dvr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= blci_pkg::DIV_CNT_W'(blci_pkg::ACC_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == blci_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift in at the bottom as dividend bits leave the top.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[blci_pkg::ACC_W-2:0], fits};
      rem_r <= fits ? rem_sub[blci_pkg::DVR_W-1:0] : rem_sh[blci_pkg::DVR_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule
